@@ design/scd_pkg.sv @@
// Shared types and constants for the sprite chain decoder.
package scd_pkg;

  localparam int unsigned PosW     = 11;
  localparam int unsigned OffW     = 5;
  localparam int unsigned NumW     = 16;
  localparam int unsigned BankW    = 4;
  localparam int unsigned ChainW   = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [8:0]      XWrapLimit = 9'd496;
  localparam logic [PosW-1:0] XFlipBase  = 11'd304;
  localparam logic [PosW-1:0] YFlipBase  = 11'd240;
  localparam logic [8:0]      YBase      = 9'd256;
  localparam logic [PosW-1:0] TileStep   = 11'd16;

  localparam logic [CfgIdxW-1:0] CfgScreenFlipped = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgXOffset       = 1'b1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCalc = 3'b010,
    StEmit = 3'b100
  } state_e;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic            mirror_x;
    logic            mirror_y;
    logic            step_up;
  } place_t;

endpackage

@@ design/sprite_chain_decoder_core.sv @@
// Sprite chain decoder top level: record capture, placement and tile sequencer.
//
//  channel   direction  handshake            payload
//  record    in         start_i / busy_o     y_byte_i attr_byte_i number_*_i colour_byte_i x_byte_i
//  command   out        valid_o (1 cycle)    tile_number_o screen_x/y_o mirror_x/y_o ...
//  config    in         cfg_we_i             cfg_idx_i cfg_data_i
//
// A record with the enable bit set first passes through the placement state
// StCalc, then StEmit gives one command per cycle for a chain of n tiles from
// the shared step adder. A disabled record is dropped at the accept edge.
// Reset clears the sequencer and both config registers.
// Commands cannot be stalled; each is on the ports for exactly one cycle.
module sprite_chain_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [7:0]                       y_byte_i,
  input  logic [7:0]                       attr_byte_i,
  input  logic [7:0]                       number_low_i,
  input  logic [7:0]                       number_high_i,
  input  logic [7:0]                       colour_byte_i,
  input  logic [7:0]                       x_byte_i,
  input  logic                             cfg_we_i,
  input  logic [scd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [scd_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                             valid_o,
  output logic [scd_pkg::NumW-1:0]         tile_number_o,
  output logic signed [scd_pkg::PosW-1:0]  screen_x_o,
  output logic signed [scd_pkg::PosW-1:0]  screen_y_o,
  output logic                             mirror_x_o,
  output logic                             mirror_y_o,
  output logic [scd_pkg::BankW-1:0]        colour_bank_o,
  output logic                             last_of_chain_o
);

  scd_pkg::state_e state_q, state_d;

  logic                              flipped_q;
  logic signed [scd_pkg::OffW-1:0]   x_offset_q;

  logic [7:0]                        attr_q;
  logic [7:0]                        x_byte_q;
  logic [7:0]                        y_byte_q;
  logic [scd_pkg::NumW-1:0]          number_q, number_d;
  logic [scd_pkg::BankW-1:0]         bank_q;
  logic [scd_pkg::ChainW-1:0]        left_q, left_d;
  logic [scd_pkg::PosW-1:0]          x_q;
  logic [scd_pkg::PosW-1:0]          y_q, y_d;
  logic                              mx_q;
  logic                              my_q;
  logic                              up_q;

  scd_pkg::place_t                   place;
  logic [scd_pkg::PosW-1:0]          step_sum;
  logic                              accept;

  scd_place u_place (
    .attr_i     (attr_q),
    .x_byte_i   (x_byte_q),
    .y_byte_i   (y_byte_q),
    .flipped_i  (flipped_q),
    .x_offset_i (x_offset_q),
    .place_o    (place)
  );

  assign accept   = start_i && (state_q == scd_pkg::StIdle);
  assign step_sum = up_q ? (y_q + scd_pkg::TileStep) : (y_q - scd_pkg::TileStep);

  always_comb begin
    state_d  = state_q;
    y_d      = y_q;
    number_d = number_q;
    left_d   = left_q;
    case (state_q)
      scd_pkg::StIdle: begin
        if (accept) begin
          number_d = {number_high_i, number_low_i};
        end
        if (start_i && attr_byte_i[0]) begin
          state_d = scd_pkg::StCalc;
        end
      end
      scd_pkg::StCalc: begin
        state_d = scd_pkg::StEmit;
        y_d     = place.y;
        left_d  = attr_q[7:5];
      end
      scd_pkg::StEmit: begin
        y_d      = step_sum;
        number_d = number_q + 16'd1;
        left_d   = left_q - 3'd1;
        if (left_q == '0) begin
          state_d = scd_pkg::StIdle;
        end
      end
      default: begin
        state_d = scd_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= scd_pkg::StIdle;
      flipped_q  <= 1'b0;
      x_offset_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          scd_pkg::CfgScreenFlipped: flipped_q  <= cfg_data_i[0];
          scd_pkg::CfgXOffset:       x_offset_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    left_q   <= left_d;
    number_q <= number_d;
    if (accept) begin
      attr_q   <= attr_byte_i;
      x_byte_q <= x_byte_i;
      y_byte_q <= y_byte_i;
      bank_q   <= colour_byte_i[scd_pkg::BankW-1:0];
    end
    if (state_q == scd_pkg::StCalc) begin
      x_q  <= place.x;
      mx_q <= place.mirror_x;
      my_q <= place.mirror_y;
      up_q <= place.step_up;
    end
  end

  assign busy_o          = (state_q != scd_pkg::StIdle);
  assign valid_o         = (state_q == scd_pkg::StEmit);
  assign tile_number_o   = number_q;
  assign screen_x_o      = x_q;
  assign screen_y_o      = y_q;
  assign mirror_x_o      = mx_q;
  assign mirror_y_o      = my_q;
  assign colour_bank_o   = bank_q;
  assign last_of_chain_o = (left_q == '0);

endmodule

@@ design/scd_place.sv @@
// Position, flip and chain start computation for one sprite record.
module scd_place (
  input  logic [7:0]                  attr_i,
  input  logic [7:0]                  x_byte_i,
  input  logic [7:0]                  y_byte_i,
  input  logic                        flipped_i,
  input  logic signed [scd_pkg::OffW-1:0] x_offset_i,
  output scd_pkg::place_t             place_o
);

  logic [8:0]                 x9;
  logic [8:0]                 y9;
  logic [8:0]                 y_inv;
  logic [scd_pkg::PosW-1:0]   off_ext;
  logic [scd_pkg::PosW-1:0]   x_wrap;
  logic [scd_pkg::PosW-1:0]   x_pos;
  logic [scd_pkg::PosW-1:0]   y_pos;
  logic [scd_pkg::PosW-1:0]   y_mir;
  logic [scd_pkg::PosW-1:0]   chain_span;
  logic                       fy;

  assign x9      = {attr_i[2], x_byte_i};
  assign y9      = {attr_i[1], y_byte_i};
  assign off_ext = {{(scd_pkg::PosW - scd_pkg::OffW){x_offset_i[scd_pkg::OffW-1]}}, x_offset_i};
  assign x_wrap  = (x9 > scd_pkg::XWrapLimit) ? {2'b11, x9} : {2'b00, x9};
  assign x_pos   = x_wrap + off_ext;
  assign y_inv   = scd_pkg::YBase - y9;
  assign y_pos   = {2'b00, y_inv} - scd_pkg::TileStep;
  assign y_mir   = scd_pkg::YFlipBase - y_pos - off_ext;
  assign fy      = attr_i[3] ^ flipped_i;
  assign chain_span = {4'b0000, attr_i[7:5], 4'b0000};

  always_comb begin
    place_o.mirror_x = attr_i[4] ^ flipped_i;
    place_o.mirror_y = fy;
    place_o.step_up  = fy;
    if (flipped_i) begin
      place_o.x = scd_pkg::XFlipBase - x_pos;
      place_o.y = fy ? y_mir : (y_mir + chain_span);
    end else begin
      place_o.x = x_pos;
      place_o.y = fy ? (y_pos - chain_span) : y_pos;
    end
  end

endmodule

@@ bench/tb_sprite_chain_decoder_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench: sprite records in, predicted draw commands compared per field.
module tb_sprite_chain_decoder_core;
  import scd_pkg::*;

  typedef struct packed {
    logic [NumW-1:0]         tile;
    logic signed [PosW-1:0]  sx;
    logic signed [PosW-1:0]  sy;
    logic                    mx;
    logic                    my;
    logic [BankW-1:0]        bank;
    logic                    last;
  } draw_t;

  class chain_scoreboard;
    draw_t                  pending_draws[$];
    bit                     flipped;
    logic signed [OffW-1:0] x_off;
    int                     errors;

    function new();
      flipped = 1'b0;
      x_off   = '0;
      errors  = 0;
    endfunction

    task log_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgScreenFlipped) begin
        flipped = data[0];
      end else if (idx == CfgXOffset) begin
        x_off = data;
      end
    endfunction

    function int pending_count();
      return pending_draws.size();
    endfunction

    // Expand one accepted record into its chain of draw commands.
    function void note_record(logic [7:0] yb, logic [7:0] attr, logic [7:0] nlo,
                              logic [7:0] nhi, logic [7:0] colb, logic [7:0] xb);
      int          x;
      int          y;
      int          n;
      int          ty;
      int          off;
      int          c;
      int          step;
      logic        fx;
      logic        fy;
      logic [15:0] num;
      draw_t       d;
      if (!attr[0]) return;
      off  = int'(x_off);
      step = int'(TileStep);
      x = int'({attr[2], xb});
      if (x > int'(XWrapLimit)) x -= 512;
      x += off;
      y = int'({attr[1], yb});
      y = ((int'(YBase) - y) & 511) - 16;
      fx = attr[4];
      fy = attr[3];
      if (flipped) begin
        fx = ~fx;
        fy = ~fy;
        y  = int'(YFlipBase) - y - off;
        x  = int'(XFlipBase) - x;
      end
      n   = int'(attr[7:5]) + 1;
      num = {nhi, nlo};
      for (c = 0; c < n; c++) begin
        if (flipped) begin
          ty = fy ? y + step * c : y + step * (n - 1) - step * c;
        end else begin
          ty = fy ? y - step * (n - 1) + step * c : y - step * c;
        end
        d.tile = num + 16'(c);
        d.sx   = PosW'(x);
        d.sy   = PosW'(ty);
        d.mx   = fx;
        d.my   = fy;
        d.bank = colb[3:0];
        d.last = (c == n - 1);
        pending_draws.push_back(d);
      end
    endfunction

    task check_draw(draw_t got);
      draw_t want;
      if (pending_draws.size() == 0) begin
        log_mismatch($sformatf("unexpected command tile=%0h", got.tile));
        return;
      end
      want = pending_draws.pop_front();
      if (got.tile != want.tile)
        log_mismatch($sformatf("tile_number %0h, want %0h", got.tile, want.tile));
      if (got.sx != want.sx)
        log_mismatch($sformatf("screen_x %0d, want %0d", got.sx, want.sx));
      if (got.sy != want.sy)
        log_mismatch($sformatf("screen_y %0d, want %0d", got.sy, want.sy));
      if (got.mx != want.mx)
        log_mismatch($sformatf("mirror_x %0b, want %0b", got.mx, want.mx));
      if (got.my != want.my)
        log_mismatch($sformatf("mirror_y %0b, want %0b", got.my, want.my));
      if (got.bank != want.bank)
        log_mismatch($sformatf("colour_bank %0h, want %0h", got.bank, want.bank));
      if (got.last != want.last)
        log_mismatch($sformatf("last_of_chain %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   start_i       = 1'b0;
  logic                   busy_o;
  logic [7:0]             y_byte_i      = '0;
  logic [7:0]             attr_byte_i   = '0;
  logic [7:0]             number_low_i  = '0;
  logic [7:0]             number_high_i = '0;
  logic [7:0]             colour_byte_i = '0;
  logic [7:0]             x_byte_i      = '0;
  logic                   cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i     = '0;
  logic [CfgDataW-1:0]    cfg_data_i    = '0;
  logic                   valid_o;
  logic [NumW-1:0]        tile_number_o;
  logic signed [PosW-1:0] screen_x_o;
  logic signed [PosW-1:0] screen_y_o;
  logic                   mirror_x_o;
  logic                   mirror_y_o;
  logic [BankW-1:0]       colour_bank_o;
  logic                   last_of_chain_o;

  chain_scoreboard sb = new();
  bit              calm = 1'b0;
  draw_t           seen_draw;

  sprite_chain_decoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .y_byte_i        (y_byte_i),
    .attr_byte_i     (attr_byte_i),
    .number_low_i    (number_low_i),
    .number_high_i   (number_high_i),
    .colour_byte_i   (colour_byte_i),
    .x_byte_i        (x_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .valid_o         (valid_o),
    .tile_number_o   (tile_number_o),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .mirror_x_o      (mirror_x_o),
    .mirror_y_o      (mirror_y_o),
    .colour_bank_o   (colour_bank_o),
    .last_of_chain_o (last_of_chain_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      seen_draw.tile = tile_number_o;
      seen_draw.sx   = screen_x_o;
      seen_draw.sy   = screen_y_o;
      seen_draw.mx   = mirror_x_o;
      seen_draw.my   = mirror_y_o;
      seen_draw.bank = colour_bank_o;
      seen_draw.last = last_of_chain_o;
      sb.check_draw(seen_draw);
    end
  end

  // Hold start until the transaction is taken, then maybe drop it for a short burst.
  task automatic send_record(input logic [7:0] yb, input logic [7:0] attr,
                             input logic [7:0] nlo, input logic [7:0] nhi,
                             input logic [7:0] colb, input logic [7:0] xb);
    start_i       <= 1'b1;
    y_byte_i      <= yb;
    attr_byte_i   <= attr;
    number_low_i  <= nlo;
    number_high_i <= nhi;
    colour_byte_i <= colb;
    x_byte_i      <= xb;
    do @(posedge clk_i); while (busy_o);
    sb.note_record(yb, attr, nlo, nhi, colb, xb);
    if (!calm && $urandom_range(0, 2) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_record();
    logic [7:0]  yb;
    logic [7:0]  attr;
    logic [7:0]  xb;
    logic [15:0] num;
    yb   = 8'($urandom);
    attr = 8'($urandom);
    xb   = 8'($urandom);
    num  = 16'($urandom);
    attr[0] = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 3) == 0) begin
      attr[2] = 1'b1;
      xb      = 8'($urandom_range(232, 255));
    end
    if ($urandom_range(0, 7) == 0) num = 16'hfff8 + 16'($urandom_range(0, 7));
    send_record(yb, attr, num[7:0], num[15:8], 8'($urandom), xb);
  endtask

  task automatic wait_quiet();
    start_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_config(input logic flip, input logic [OffW-1:0] off);
    logic [CfgDataW-1:0] flip_word;
    flip_word    = CfgDataW'($urandom);
    flip_word[0] = flip;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgScreenFlipped;
    cfg_data_i <= flip_word;
    @(posedge clk_i);
    sb.set_reg(CfgScreenFlipped, flip_word);
    cfg_idx_i  <= CfgXOffset;
    cfg_data_i <= off;
    @(posedge clk_i);
    sb.set_reg(CfgXOffset, off);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic             phase_flip[6];
    logic [OffW-1:0]  phase_off[6];
    int               p;
    int               k;
    phase_flip = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_off  = '{5'b10000, 5'b01111, 5'b00000, 5'b01111, 5'b11111, 5'b00000};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_record(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_record(8'hff, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff);
    send_record(8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
    send_record(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_record(8'h40, 8'h05, 8'h10, 8'h00, 8'h03, 8'hf0);
    send_record(8'h40, 8'h05, 8'h11, 8'h00, 8'h03, 8'hf1);
    send_record(8'h00, 8'h03, 8'h12, 8'h00, 8'h07, 8'h80);
    send_record(8'hff, 8'h01, 8'h13, 8'h00, 8'h08, 8'h00);
    send_record(8'h80, 8'he1, 8'h20, 8'h01, 8'h01, 8'h20);
    send_record(8'h80, 8'he9, 8'h30, 8'h01, 8'h02, 8'h20);
    send_record(8'h80, 8'hf1, 8'h40, 8'h01, 8'h0c, 8'h20);
    send_record(8'h10, 8'h79, 8'hfe, 8'hff, 8'h0f, 8'h60);
    send_record(8'h55, 8'h21, 8'haa, 8'h55, 8'hf5, 8'haa);
    wait_quiet();

    set_config(1'b1, 5'b10000);
    send_record(8'h80, 8'he1, 8'h00, 8'h02, 8'h01, 8'h20);
    send_record(8'h80, 8'he9, 8'h10, 8'h02, 8'h02, 8'h20);
    send_record(8'h80, 8'hf1, 8'h20, 8'h02, 8'h03, 8'h20);
    send_record(8'hff, 8'hf9, 8'hff, 8'hff, 8'hff, 8'hff);
    send_record(8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'hf1);
    wait_quiet();

    for (p = 0; p < 6; p++) begin
      if (p == 5) begin
        calm = 1'b1;
        set_config(1'($urandom), OffW'($urandom));
      end else begin
        set_config(phase_flip[p], phase_off[p]);
      end
      for (k = 0; k < 16; k++) send_random_record();
      wait_quiet();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sprite_chain_decoder_core.f @@
design/scd_pkg.sv
design/scd_place.sv
design/sprite_chain_decoder_core.sv
bench/tb_sprite_chain_decoder_core.sv
